// ===== hdl/lmst_pkg.sv =====
// shared constants, types and register codes for the local mean/stddev threshold block
// no dependencies
package lmst_pkg;

  localparam int HALF_WINDOW_DEF = 15;
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;

  localparam int DIM_W      = 9;
  localparam int K_W        = 16;
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MUL_W      = 32;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd256;
  localparam logic [K_W-1:0]   K_RESET      = 16'd655;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K      = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic [MUL_W-1:0] sum;
    logic [MUL_W-1:0] sq_sum;
    logic [PIX_W-1:0] center;
  } win_stats_t;

endpackage

// ===== hdl/lmst_if.sv =====
// valid/ready channel interfaces for request words and result words
// depends on lmst_pkg
interface lmst_req_if;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [lmst_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output kind, output pixel, input ready);
  modport sink (input valid, input kind, input pixel, output ready);
endinterface

interface lmst_res_if;
  logic valid;
  logic ready;
  logic above;
  logic final_pixel;
  modport source (output valid, output above, output final_pixel, input ready);
  modport sink (input valid, input above, input final_pixel, output ready);
endinterface

// ===== hdl/local_mean_stddev_threshold_top.sv =====
// local mean/stddev (niblack style) binary threshold over a full-size square window
// depends on lmst_pkg, lmst_if, lmst_ram, lmst_win, lmst_cmp
//
// request channel: kind 0 loads the next pixel of the frame in raster order, kind 1
// fetches the result for the next pixel. loads, one per idle cycle, give no word;
// a load after the frame is complete is dropped. a fetch before the frame is complete
// gives no word. result words carry above and final_pixel; after the last pixel the
// block starts over with a new frame.
// a fetch holds the request channel from its accept until its result word is loaded
// into the output register:
// the single read port of the frame memory reads every window pixel once, then the
// shared multiplier runs a 10 step sequence. one request is in work at a time.
// the result sits in an output register; when the receiver stalls the block finishes
// its work and waits there, without accepting the next request.
// config writes (index 0 width, 1 height, 2 k) are taken any cycle and restart the
// frame. reset is synchronous and clears positions and config to defaults; frame
// memory contents are not cleared.
module local_mean_stddev_threshold_top #(
  parameter int HALF_WINDOW = lmst_pkg::HALF_WINDOW_DEF,
  parameter int MAX_WIDTH   = lmst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = lmst_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lmst_req_if.sink                        request,
  lmst_res_if.source                      result,
  input  logic                            cfg_we,
  input  logic [lmst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lmst_pkg::*;

  localparam int SPAN   = 2 * HALF_WINDOW + 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {S_IDLE, S_WIN, S_ACC, S_CMP, S_OUT} state_t;

  state_t            state;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [K_W-1:0]    k_fraction;
  logic [CW-1:0]     w_eff;
  logic [RW-1:0]     h_eff;
  logic [CW-1:0]     lcol, ecol, c0;
  logic [RW-1:0]     lrow, erow, r0;
  logic              loaded;
  logic              load_last, emit_last;
  logic              accept, ram_we;
  logic [ADDR_W-1:0] waddr, raddr, win_addr, ctr_addr;
  logic [PIX_W-1:0]  rdata;
  logic              win_done, cmp_done, cmp_above;
  win_stats_t        stats;

  always_comb begin
    if (image_width < DIM_W'(SPAN)) w_eff = CW'(SPAN);
    else if (int'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    if (image_height < DIM_W'(SPAN)) h_eff = RW'(SPAN);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(image_height);
  end

  // window is shifted inward at the borders so it stays full size
  always_comb begin
    if (int'(erow) < HALF_WINDOW) r0 = '0;
    else if (int'(erow) + HALF_WINDOW + 1 > int'(h_eff)) r0 = RW'(int'(h_eff) - SPAN);
    else r0 = RW'(int'(erow) - HALF_WINDOW);
    if (int'(ecol) < HALF_WINDOW) c0 = '0;
    else if (int'(ecol) + HALF_WINDOW + 1 > int'(w_eff)) c0 = CW'(int'(w_eff) - SPAN);
    else c0 = CW'(int'(ecol) - HALF_WINDOW);
  end

  assign load_last = (lrow == h_eff - 1'b1) && (lcol == w_eff - 1'b1);
  assign emit_last = (erow == h_eff - 1'b1) && (ecol == w_eff - 1'b1);
  assign request.ready = (state == S_IDLE);
  assign accept   = request.valid && request.ready;
  assign ram_we   = accept && (request.kind == KIND_LOAD) && !loaded;
  assign waddr    = ADDR_W'(ADDR_W'(lrow) * ADDR_W'(MAX_WIDTH) + ADDR_W'(lcol));
  assign win_addr = ADDR_W'(ADDR_W'(r0) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c0));
  assign ctr_addr = ADDR_W'(ADDR_W'(erow) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ecol));

  lmst_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (request.pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  lmst_win #(.HALF_WINDOW(HALF_WINDOW), .MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_win (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_WIN),
    .win_addr (win_addr),
    .ctr_addr (ctr_addr),
    .rd_addr  (raddr),
    .rd_data  (rdata),
    .done     (win_done),
    .stats    (stats)
  );

  lmst_cmp #(.NPIX(SPAN * SPAN)) u_cmp (
    .clk        (clk),
    .rst        (rst),
    .start      ((state == S_ACC) && win_done),
    .stats      (stats),
    .k_fraction (k_fraction),
    .done       (cmp_done),
    .above      (cmp_above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      k_fraction   <= K_RESET;
      lrow         <= '0;
      lcol         <= '0;
      erow         <= '0;
      ecol         <= '0;
      loaded       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.kind == KIND_LOAD) begin
              if (!loaded) begin
                if (load_last) begin
                  loaded <= 1'b1;
                end else if (lcol == w_eff - 1'b1) begin
                  lcol <= '0;
                  lrow <= lrow + 1'b1;
                end else begin
                  lcol <= lcol + 1'b1;
                end
              end
            end else if (loaded) begin
              state <= S_WIN;
            end
          end
        end
        S_WIN: state <= S_ACC;
        S_ACC: if (win_done) state <= S_CMP;
        S_CMP: if (cmp_done) state <= S_OUT;
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.above       <= cmp_above;
            result.final_pixel <= emit_last;
            state              <= S_IDLE;
            if (emit_last) begin
              lrow   <= '0;
              lcol   <= '0;
              erow   <= '0;
              ecol   <= '0;
              loaded <= 1'b0;
            end else if (ecol == w_eff - 1'b1) begin
              ecol <= '0;
              erow <= erow + 1'b1;
            end else begin
              ecol <= ecol + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
          REG_K:      k_fraction   <= cfg_data[K_W-1:0];
          default: ;
        endcase
        if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT || cfg_index == REG_K) begin
          lrow   <= '0;
          lcol   <= '0;
          erow   <= '0;
          ecol   <= '0;
          loaded <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== hdl/lmst_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lmst_win.sv =====
// window sweep: reads the center pixel and every window pixel from frame memory,
// accumulating sum and sum of squares; depends on lmst_pkg
module lmst_win #(
  parameter int HALF_WINDOW = lmst_pkg::HALF_WINDOW_DEF,
  parameter int MAX_WIDTH   = lmst_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W      = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ADDR_W-1:0]          win_addr,
  input  logic [ADDR_W-1:0]          ctr_addr,
  output logic [ADDR_W-1:0]          rd_addr,
  input  logic [lmst_pkg::PIX_W-1:0] rd_data,
  output logic                       done,
  output lmst_pkg::win_stats_t       stats
);
  import lmst_pkg::*;

  localparam int SPAN  = 2 * HALF_WINDOW + 1;
  localparam int CNT_W = $clog2(SPAN);

  typedef enum logic [2:0] {IDLE, CTR, SWEEP, FLUSH, DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  wr;
  logic [CNT_W-1:0]  wc;
  logic [ADDR_W-1:0] row_addr;
  logic              rd_win;
  logic              rd_ctr;
  logic [2*PIX_W-1:0] sq;

  assign sq      = rd_data * rd_data;
  assign rd_addr = (state == CTR) ? ctr_addr : row_addr + ADDR_W'(wc);
  assign done    = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      rd_win <= 1'b0;
      rd_ctr <= 1'b0;
    end else begin
      rd_win <= (state == SWEEP);
      rd_ctr <= (state == CTR);
      if (rd_ctr) begin
        stats.center <= rd_data;
      end
      if (rd_win) begin
        stats.sum    <= stats.sum + MUL_W'(rd_data);
        stats.sq_sum <= stats.sq_sum + MUL_W'(sq);
      end
      case (state)
        IDLE: begin
          if (start) begin
            row_addr     <= win_addr;
            wr           <= '0;
            wc           <= '0;
            stats.sum    <= '0;
            stats.sq_sum <= '0;
            state        <= CTR;
          end
        end
        CTR: state <= SWEEP;
        SWEEP: begin
          if (wc == CNT_W'(SPAN - 1)) begin
            wc       <= '0;
            wr       <= wr + 1'b1;
            row_addr <= row_addr + ADDR_W'(MAX_WIDTH);
            if (wr == CNT_W'(SPAN - 1)) begin
              state <= FLUSH;
            end
          end else begin
            wc <= wc + 1'b1;
          end
        end
        FLUSH: state <= DONE;
        DONE: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/lmst_cmp.sv =====
// threshold test on one shared 32x32 multiplier, stepped by a small sequencer:
// above = (n*p > S) and (2^32 * (n*p-S)^2 > k^2 * (n*Q - S^2)); depends on lmst_pkg
module lmst_cmp #(
  parameter int NPIX = 961
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  lmst_pkg::win_stats_t       stats,
  input  logic [lmst_pkg::K_W-1:0]   k_fraction,
  output logic                       done,
  output logic                       above
);
  import lmst_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NP, ST_SS, ST_NQ, ST_SUB, ST_AA, ST_KK, ST_LO, ST_HI, ST_SUM, ST_CMP, ST_DONE
  } state_t;

  state_t             state;
  logic [MUL_W-1:0]   opa;
  logic [MUL_W-1:0]   opb;
  logic [2*MUL_W-1:0] prod;
  logic [2*MUL_W-1:0] np, ss, nq, d, aa, lo, hi;
  logic [MUL_W-1:0]   a;
  logic [MUL_W-1:0]   kk;
  logic [3*MUL_W-1:0] rhs;
  logic               pos;

  always_comb begin
    opa = '0;
    opb = '0;
    case (state)
      ST_NP: begin
        opa = MUL_W'(NPIX);
        opb = MUL_W'(stats.center);
      end
      ST_SS: begin
        opa = stats.sum;
        opb = stats.sum;
      end
      ST_NQ: begin
        opa = MUL_W'(NPIX);
        opb = stats.sq_sum;
      end
      ST_AA: begin
        opa = a;
        opb = a;
      end
      ST_KK: begin
        opa = MUL_W'(k_fraction);
        opb = MUL_W'(k_fraction);
      end
      ST_LO: begin
        opa = kk;
        opb = d[MUL_W-1:0];
      end
      ST_HI: begin
        opa = kk;
        opb = d[2*MUL_W-1:MUL_W];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;
  assign done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      above <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (start) state <= ST_NP;
        ST_NP: begin
          np    <= prod;
          state <= ST_SS;
        end
        ST_SS: begin
          ss    <= prod;
          state <= ST_NQ;
        end
        ST_NQ: begin
          nq    <= prod;
          state <= ST_SUB;
        end
        ST_SUB: begin
          pos   <= (np > {{MUL_W{1'b0}}, stats.sum});
          a     <= np[MUL_W-1:0] - stats.sum;
          d     <= nq - ss;
          state <= ST_AA;
        end
        ST_AA: begin
          aa    <= prod;
          state <= ST_KK;
        end
        ST_KK: begin
          kk    <= prod[MUL_W-1:0];
          state <= ST_LO;
        end
        ST_LO: begin
          lo    <= prod;
          state <= ST_HI;
        end
        ST_HI: begin
          hi    <= prod;
          state <= ST_SUM;
        end
        ST_SUM: begin
          rhs   <= {hi, {MUL_W{1'b0}}} + {{MUL_W{1'b0}}, lo};
          state <= ST_CMP;
        end
        ST_CMP: begin
          above <= pos && ({aa, {MUL_W{1'b0}}} > rhs);
          state <= ST_DONE;
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
